>>> sv/slc_pkg.sv
// Shared sizes, row layout and result type for the LRU cache tag store.
package slc_pkg;

    // Geometry limits
    localparam int MAX_SETS   = 64;
    localparam int MAX_WAYS   = 8;
    localparam int ADDR_WIDTH = 64;

    // Fixed field widths of the ports
    localparam int ADDR_FW  = 64;
    localparam int CNT_W    = 32;
    localparam int CFG_SB_W = 3;
    localparam int CFG_BB_W = 5;
    localparam int CFG_WY_W = 4;
    localparam int CFG_D_W  = 5;
    localparam int CFG_I_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_I_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_I_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_I_W-1:0] CFG_WAYS_USED  = 2'd2;

    // Input commands
    localparam logic CMD_LDST   = 1'b0;
    localparam logic CMD_MODIFY = 1'b1;

    // Derived sizes
    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SB_MAX  = $clog2(MAX_SETS + 1) - 1;
    localparam int TAG_W   = ADDR_WIDTH - 1;
    localparam int RANK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WIDX_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
    localparam int SH_W    = CFG_BB_W + 1;

    localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(MAX_WAYS - 1);

    // One set of the tag store
    typedef struct packed {
        logic [MAX_WAYS-1:0]             vld;
        logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    } t_row;

    // Outcome of one lookup
    typedef struct packed {
        logic hit;
        logic evicted;
    } t_look_res;

endpackage

>>> sv/slc_in_if.sv
// Input channel: command and byte address.
interface slc_in_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [slc_pkg::ADDR_FW-1:0] address;

    modport source (output valid, output cmd, output address, input ready);
    modport sink   (input valid, input cmd, input address, output ready);
endinterface

>>> sv/slc_out_if.sv
// Output channel: per-lookup outcome and running totals.
interface slc_out_if;
    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic                      evicted;
    logic                      last;
    logic [slc_pkg::CNT_W-1:0] hit_total;
    logic [slc_pkg::CNT_W-1:0] miss_total;
    logic [slc_pkg::CNT_W-1:0] evict_total;

    modport source (output valid, output hit, output evicted, output last,
                    output hit_total, output miss_total, output evict_total,
                    input ready);
    modport sink   (input valid, input hit, input evicted, input last,
                    input hit_total, input miss_total, input evict_total,
                    output ready);
endinterface

>>> sv/slc_lookup.sv
// Tag compare, LRU rank update and victim choice for one set.
module slc_lookup (
    input  slc_pkg::t_row                 i_row,
    input  logic                          i_live,
    input  logic [slc_pkg::TAG_W-1:0]     i_tag,
    input  logic [slc_pkg::WCNT_W-1:0]    i_ways,
    output slc_pkg::t_row                 o_row,
    output slc_pkg::t_look_res            o_res
);
    import slc_pkg::*;

    // Search the set, then promote a hit line, or age and install on a miss
    always_comb begin
        t_row              row;
        logic              found_f;
        logic              empty_f;
        logic [WIDX_W-1:0] found_w;
        logic [WIDX_W-1:0] empty_w;
        logic [WIDX_W-1:0] vic_w;
        logic [RANK_W-1:0] best;
        logic [RANK_W-1:0] hit_rank;

        row = i_row;
        if (!i_live) begin
            row.vld  = '0;
            row.rank = '0;
        end

        found_f = 1'b0;
        empty_f = 1'b0;
        found_w = '0;
        empty_w = '0;
        vic_w   = '0;
        best    = '0;

        for (int w = 0; w < MAX_WAYS; w++) begin
            if (w < int'(i_ways)) begin
                if (row.vld[w]) begin
                    if (!found_f && row.tag[w] == i_tag) begin
                        found_f = 1'b1;
                        found_w = WIDX_W'(w);
                    end
                end else if (!empty_f) begin
                    empty_f = 1'b1;
                    empty_w = WIDX_W'(w);
                end
                // oldest way, lowest index on a tie
                if (w == 0 || row.rank[w] > best) begin
                    best  = row.rank[w];
                    vic_w = WIDX_W'(w);
                end
            end
        end

        hit_rank = row.rank[found_w];
        o_row    = row;
        o_res.hit     = found_f;
        o_res.evicted = !found_f && !empty_f;

        if (found_f) begin
            // promote the hit line, age the younger ones
            for (int w = 0; w < MAX_WAYS; w++) begin
                if (w < int'(i_ways) && row.vld[w] && row.rank[w] < hit_rank) begin
                    o_row.rank[w] = row.rank[w] + 1'b1;
                end
            end
            o_row.rank[found_w] = '0;
        end else begin
            if (empty_f) begin
                vic_w = empty_w;
            end
            // age every valid line in the used ways below the top rank, then install the new one
            for (int w = 0; w < MAX_WAYS; w++) begin
                if (w < int'(i_ways) && row.vld[w] && row.rank[w] < RANK_TOP) begin
                    o_row.rank[w] = row.rank[w] + 1'b1;
                end
            end
            o_row.vld[vic_w]  = 1'b1;
            o_row.tag[vic_w]  = i_tag;
            o_row.rank[vic_w] = '0;
        end
    end

endmodule

>>> sv/set_assoc_lru_cache_tags.sv
// Top level of the set-associative LRU cache tag store.
//
//  channel  | dir | handshake        | word
//  ---------+-----+------------------+---------------------------------------------
//  i_in     | in  | valid / ready    | cmd, address
//  o_out    | out | valid / ready    | hit, evicted, last, hit/miss/evict totals
//  i_cfg_*  | in  | write enable     | idx 0 set_bits, 1 block_bits, 2 ways_used
//
// A load or store reads the set from the tag RAM when the word is accepted,
// then updates it and writes it back. A modify does a second lookup that
// reuses the row just written, held in a forwarding register. Reset clears
// per-set valid flags at once; no clearing pass is needed. A stalled output
// word holds the block in its update cycle; one new input word can be taken
// while a result waits.
module set_assoc_lru_cache_tags (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [slc_pkg::CFG_I_W-1:0]   i_cfg_idx,
    input  logic [slc_pkg::CFG_D_W-1:0]   i_cfg_data,
    slc_in_if.sink                        i_in,
    slc_out_if.source                     o_out
);
    import slc_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOOK  = 2'd1;
    localparam logic [1:0] S_LOOK2 = 2'd2;

    // Configuration
    logic [CFG_SB_W-1:0] r_cfg_sb;
    logic [CFG_BB_W-1:0] r_cfg_bb;
    logic [CFG_WY_W-1:0] r_cfg_ways;

    // Control and item state
    logic [1:0]          r_state, n_state;
    logic                r_cmd;
    logic [TAG_W-1:0]    r_tag;
    logic [SET_W-1:0]    r_set;
    logic                r_row_live;
    logic [MAX_SETS-1:0] r_row_vld;

    // Tag RAM
    t_row                r_mem [MAX_SETS];
    t_row                r_rd_row;
    t_row                r_fwd_row;

    // Output
    logic                r_out_vld;
    logic                r_out_hit;
    logic                r_out_evicted;
    logic                r_out_last;
    logic [CNT_W-1:0]    r_hits;
    logic [CNT_W-1:0]    r_misses;
    logic [CNT_W-1:0]    r_evicts;

    logic                in_acc;
    logic                out_free;
    logic                commit;
    logic [CFG_SB_W-1:0] sb_eff;
    logic [WCNT_W-1:0]   ways_eff;
    logic [ADDR_FW-1:0]  addr_m;
    logic [SH_W-1:0]     tag_sh;
    logic [ADDR_FW-1:0]  tag_full;
    logic [ADDR_FW-1:0]  set_full;
    logic [SET_W-1:0]    set_mask;
    logic [SET_W-1:0]    n_set;
    logic [TAG_W-1:0]    n_tag;
    t_row                lk_row_in;
    logic                lk_live;
    t_row                lk_row_out;
    t_look_res           lk_res;

    // Clamp configuration into its usable range
    always_comb begin
        if (r_cfg_sb == '0) begin
            sb_eff = CFG_SB_W'(1);
        end else if (int'(r_cfg_sb) > SB_MAX) begin
            sb_eff = CFG_SB_W'(SB_MAX);
        end else begin
            sb_eff = r_cfg_sb;
        end
        if (r_cfg_ways == '0) begin
            ways_eff = WCNT_W'(1);
        end else if (int'(r_cfg_ways) > MAX_WAYS) begin
            ways_eff = WCNT_W'(MAX_WAYS);
        end else begin
            ways_eff = WCNT_W'(r_cfg_ways);
        end
    end

    // Split the incoming address into set and tag
    always_comb begin
        addr_m   = ADDR_FW'(i_in.address[ADDR_WIDTH-1:0]);
        tag_sh   = SH_W'(r_cfg_bb) + SH_W'(sb_eff);
        tag_full = addr_m >> tag_sh;
        set_full = addr_m >> r_cfg_bb;
        set_mask = ~({SET_W{1'b1}} << sb_eff);
        n_tag    = tag_full[TAG_W-1:0];
        n_set    = set_full[SET_W-1:0] & set_mask;
    end

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign out_free   = !r_out_vld || o_out.ready;
    assign commit     = (r_state == S_LOOK || r_state == S_LOOK2) && out_free;

    // Second lookup of a modify sees the row just written
    assign lk_row_in = (r_state == S_LOOK2) ? r_fwd_row : r_rd_row;
    assign lk_live   = (r_state == S_LOOK2) ? 1'b1 : r_row_live;

    slc_lookup u_lookup (
        .i_row  (lk_row_in),
        .i_live (lk_live),
        .i_tag  (r_tag),
        .i_ways (ways_eff),
        .o_row  (lk_row_out),
        .o_res  (lk_res)
    );

    // Sequence the lookups of one item
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (commit) begin
                    n_state = (r_cmd == CMD_MODIFY) ? S_LOOK2 : S_IDLE;
                end
            end
            S_LOOK2: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Read the set on accept, write it back on commit
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_row <= r_mem[n_set];
        end
        if (commit) begin
            r_mem[r_set] <= lk_row_out;
        end
    end

    // Hold item payload and forwarded row
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_in.cmd;
            r_tag <= n_tag;
            r_set <= n_set;
        end
        if (commit) begin
            r_fwd_row     <= lk_row_out;
            r_out_hit     <= lk_res.hit;
            r_out_evicted <= lk_res.evicted;
            r_out_last    <= (r_state == S_LOOK2) || (r_cmd == CMD_LDST);
        end
    end

    // Control state, set valid flags, totals and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_row_vld  <= '0;
            r_row_live <= 1'b0;
            r_out_vld  <= 1'b0;
            r_hits     <= '0;
            r_misses   <= '0;
            r_evicts   <= '0;
            r_cfg_sb   <= CFG_SB_W'(1);
            r_cfg_bb   <= CFG_BB_W'(4);
            r_cfg_ways <= CFG_WY_W'(8);
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_row_live <= r_row_vld[n_set];
            end
            if (commit) begin
                r_row_vld[r_set] <= 1'b1;
                r_out_vld        <= 1'b1;
                if (lk_res.hit) begin
                    if (r_hits != '1) begin
                        r_hits <= r_hits + 1'b1;
                    end
                end else begin
                    if (r_misses != '1) begin
                        r_misses <= r_misses + 1'b1;
                    end
                    if (lk_res.evicted && r_evicts != '1) begin
                        r_evicts <= r_evicts + 1'b1;
                    end
                end
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SET_BITS:   r_cfg_sb   <= i_cfg_data[CFG_SB_W-1:0];
                    CFG_BLOCK_BITS: r_cfg_bb   <= i_cfg_data[CFG_BB_W-1:0];
                    CFG_WAYS_USED:  r_cfg_ways <= i_cfg_data[CFG_WY_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Drive the output word
    assign o_out.valid       = r_out_vld;
    assign o_out.hit         = r_out_hit;
    assign o_out.evicted     = r_out_evicted;
    assign o_out.last        = r_out_last;
    assign o_out.hit_total   = r_hits;
    assign o_out.miss_total  = r_misses;
    assign o_out.evict_total = r_evicts;

endmodule
